>>> sv/spf_pkg.sv
// Shared types, constants and helpers of the per-PC stride prefetcher.
package spf_pkg;

   localparam int SPF_TABLE_ENTRIES = 256;
   localparam int ADDR_W            = 48;
   localparam int LINE_W            = 44;
   localparam int STRIDE_W          = 45;
   localparam int TGT_W             = 47;
   localparam int CONF_W            = 2;
   localparam int SHIFT_W           = 4;
   localparam int QUEUE_DEPTH       = 4;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;

   localparam logic [CONF_W-1:0]  CONF_MAX      = 2'd3;
   localparam logic [SHIFT_W-1:0] PAGE_SHIFT    = 4'd12;
   localparam logic [SHIFT_W-1:0] SHIFT_MIN     = 4'd4;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX     = 4'd12;
   localparam logic [SHIFT_W-1:0] LINE_LOG2_RST = 4'd6;

   // register index, taken from paddr[2]
   localparam logic REG_LINE_SIZE = 1'b0;

   typedef struct packed {
      logic [ADDR_W-1:0] pc;
      logic [LINE_W-1:0] line;
      logic              miss;
   } spf_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0]          tag;
      logic [LINE_W-1:0]          prev_line;
      logic signed [STRIDE_W-1:0] stride;
      logic [CONF_W-1:0]          conf;
   } spf_entry_type;

   function automatic logic [SHIFT_W-1:0] spf_eff_shift(input logic [SHIFT_W-1:0] log2);
      logic [SHIFT_W-1:0] sh;
      sh = log2;
      if (log2 < SHIFT_MIN) sh = SHIFT_MIN;
      if (log2 > SHIFT_MAX) sh = SHIFT_MAX;
      return sh;
   endfunction

endpackage

>>> sv/spf_queue.sv
// Small first-in first-out queue of fixed-width items.
module spf_queue import spf_pkg::*; #(
   parameter int WIDTH = ADDR_W,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> sv/spf_front.sv
// Front end: accepts accesses, drops generated prefetches, forms the line number.
module spf_front import spf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [SHIFT_W-1:0] line_shift,
   input  logic               push,
   output logic               full,
   input  logic [ADDR_W-1:0]  access_pc,
   input  logic [ADDR_W-1:0]  access_addr,
   input  logic               miss,
   input  logic               is_prefetch,
   input  logic               q_full,
   output logic               q_push,
   output spf_item_type       q_item
);

   logic         stage_valid_ff, stage_valid_in;
   spf_item_type stage_ff;
   logic         room, accept, keep;
   logic [ADDR_W-1:0] line_wide;

   assign room   = !stage_valid_ff || !q_full;
   assign full   = !room;
   assign accept = push && room;
   assign keep   = accept && !is_prefetch;
   assign q_push = stage_valid_ff && !q_full;
   assign q_item = stage_ff;

   // shift is at least 4, so the line number fits in LINE_W bits
   assign line_wide = access_addr >> line_shift;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (q_push) stage_valid_in = 1'b0;
      if (keep)   stage_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         stage_ff.pc   <= access_pc;
         stage_ff.line <= line_wide[LINE_W-1:0];
         stage_ff.miss <= miss;
      end
   end

endmodule

>>> sv/spf_back.sv
// Back end: stride table lookup, training and prefetch target check.
module spf_back import spf_pkg::*; #(
   parameter int TABLE_ENTRIES = SPF_TABLE_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [SHIFT_W-1:0] line_shift,
   input  logic               q_empty,
   input  spf_item_type       q_item,
   output logic               q_pop,
   input  logic               out_full,
   output logic               out_push,
   output logic [ADDR_W-1:0]  out_addr
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int TADDR_W = TGT_W - 1 + 12;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EVAL = 1'b1;

   logic state_ff, state_in;
   spf_item_type  cur_ff;
   spf_entry_type mem [TABLE_ENTRIES];
   spf_entry_type rd_ff;
   spf_entry_type wr_entry;
   logic          rd_valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [IDX_W-1:0] rd_idx, wr_idx;
   logic          start, wr_en;

   logic                       hit, same, fire, in_page;
   logic signed [STRIDE_W-1:0] stride;
   logic [CONF_W-1:0]          new_conf, inc_conf;
   logic [TGT_W-1:0]           target;
   logic [SHIFT_W-1:0]         pg_sh;
   logic [TADDR_W-1:0]         taddr_wide;

   // one item at a time: read in IDLE, update in EVAL, so no bypass is needed
   assign start  = (state_ff == ST_IDLE) && !q_empty && !out_full;
   assign wr_en  = (state_ff == ST_EVAL);
   assign q_pop  = start;
   assign rd_idx = q_item.pc[IDX_W-1:0];
   assign wr_idx = cur_ff.pc[IDX_W-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_EVAL;
         ST_EVAL: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign hit    = rd_valid_ff && (rd_ff.tag == cur_ff.pc);
   assign stride = $signed({1'b0, cur_ff.line}) - $signed({1'b0, rd_ff.prev_line});
   assign same   = (stride == rd_ff.stride) && (stride != '0);
   assign inc_conf = (rd_ff.conf == CONF_MAX) ? CONF_MAX : rd_ff.conf + 1'b1;
   assign new_conf = same ? inc_conf : '0;

   // target = line + stride; top bit is the sign
   assign target = {{(TGT_W-LINE_W){1'b0}}, cur_ff.line}
                 + {{(TGT_W-STRIDE_W){stride[STRIDE_W-1]}}, stride};
   assign pg_sh  = PAGE_SHIFT - line_shift;
   assign in_page = (target[TGT_W-2:0] >> pg_sh)
                 == ({{(TGT_W-1-LINE_W){1'b0}}, cur_ff.line} >> pg_sh);
   assign taddr_wide = {{(TADDR_W-TGT_W+1){1'b0}}, target[TGT_W-2:0]} << line_shift;

   assign fire = hit && (new_conf != '0) && (cur_ff.miss || new_conf == CONF_MAX)
              && !target[TGT_W-1] && in_page;
   assign out_push = wr_en && fire;
   assign out_addr = taddr_wide[ADDR_W-1:0];

   always_comb begin
      if (hit) begin
         wr_entry.tag       = rd_ff.tag;
         wr_entry.prev_line = cur_ff.line;
         wr_entry.stride    = stride;
         wr_entry.conf      = new_conf;
      end else begin
         wr_entry.tag       = cur_ff.pc;
         wr_entry.prev_line = cur_ff.line;
         wr_entry.stride    = '0;
         wr_entry.conf      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (wr_en) valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cur_ff      <= q_item;
         rd_ff       <= mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
      end
      if (wr_en) mem[wr_idx] <= wr_entry;
   end

endmodule

>>> sv/per_pc_stride_prefetcher.sv
// Top level of the per-PC stride prefetcher: config register, front, back and queues.
//
//   channel   direction  handshake              payload
//   req       in         push / full            req_access_pc, req_access_addr,
//                                               req_miss, req_is_prefetch
//   rsp       out        empty / pop            rsp_prefetch_addr
//   csr       in/out     psel/penable/pready    paddr, pwdata, prdata
//
// Front takes one access per cycle while it has room (full low); a generated
// prefetch is dropped there. The back end handles one training access at a
// time (table read in IDLE, then update in EVAL) and starts no new one before
// the update, as the table is single-port. A result passes the front stage,
// the middle queue, the back end's read registers and the result queue.
// Reset clears valid bits at once; no clearing pass. A full result queue stalls
// only the back end; the front keeps filling the middle queue until it fills.
module per_pc_stride_prefetcher import spf_pkg::*; #(
   parameter int TABLE_ENTRIES = SPF_TABLE_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [ADDR_W-1:0]     req_access_pc,
   input  logic [ADDR_W-1:0]     req_access_addr,
   input  logic                  req_miss,
   input  logic                  req_is_prefetch,
   output logic                  empty,
   input  logic                  pop,
   output logic [ADDR_W-1:0]     rsp_prefetch_addr,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [SHIFT_W-1:0] line_log2_ff;
   logic [SHIFT_W-1:0] line_shift;
   logic               csr_write;

   logic         mid_push, mid_full, mid_pop, mid_empty;
   spf_item_type mid_in_item, mid_out_item;
   logic         out_push, out_full;
   logic [ADDR_W-1:0] out_addr;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_LINE_SIZE);
   assign prdata    = (paddr[2] == REG_LINE_SIZE)
                    ? {{(CSR_DATA_W-SHIFT_W){1'b0}}, line_log2_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_log2_ff <= LINE_LOG2_RST;
      end else if (csr_write) begin
         line_log2_ff <= pwdata[SHIFT_W-1:0];
      end
   end

   assign line_shift = spf_eff_shift(line_log2_ff);

   spf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .line_shift  (line_shift),
      .push        (push),
      .full        (full),
      .access_pc   (req_access_pc),
      .access_addr (req_access_addr),
      .miss        (req_miss),
      .is_prefetch (req_is_prefetch),
      .q_full      (mid_full),
      .q_push      (mid_push),
      .q_item      (mid_in_item)
   );

   spf_queue #(
      .WIDTH ($bits(spf_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out_item),
      .empty     (mid_empty)
   );

   spf_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .line_shift (line_shift),
      .q_empty    (mid_empty),
      .q_item     (mid_out_item),
      .q_pop      (mid_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_addr   (out_addr)
   );

   spf_queue #(
      .WIDTH (ADDR_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_addr),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_prefetch_addr),
      .empty     (empty)
   );

`ifndef ASSERT_OFF
   // back end only starts an access when the result queue has room
   a_out_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into full queue");

   a_mid_room: assert property (@(posedge clock) disable iff (reset)
      mid_push |-> !mid_full)
      else $error("item pushed into full middle queue");

   a_aligned: assert property (@(posedge clock) disable iff (reset)
      out_push |-> ((out_addr & ((ADDR_W'(1) << line_shift) - ADDR_W'(1))) == '0))
      else $error("prefetch address not line aligned");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");
`endif

endmodule
